@@ sv/fpbd_pkg.sv @@
// Package for the full-poll burst detector: beat types, the cell control struct,
// register index codes and width constants. No dependencies.
package fpbd_pkg;

    localparam int TIME_W         = 48;
    localparam int MASK_W         = 3;
    localparam int COUNT_W        = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int CONTIG_W       = 12;
    localparam int WINDOW_W       = 16;
    localparam int MS_PER_SEC     = 1000;
    // Thresholds are kept in milliseconds: 4095 s and 65535 s scaled by 1000.
    localparam int CONTIG_MS_W    = 22;
    localparam int WINDOW_MS_W    = 26;
    localparam int RING_DEPTH_DEF = 8;

    localparam logic [MASK_W-1:0]      ALL_REQUESTS  = 3'b111;
    localparam logic [COUNT_W-1:0]     COUNT_MAX     = '1;
    localparam logic [CONTIG_MS_W-1:0] CONTIG_MS_RST = 22'd2000;
    localparam logic [WINDOW_MS_W-1:0] WINDOW_MS_RST = 26'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_CONTIG = 2'd1,
        CFG_WINDOW = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [MASK_W-1:0] request_mask;
        logic [TIME_W-1:0] now_ms;
    } t_in_beat;

    typedef struct packed {
        logic               complete;
        logic               alarm;
        logic [COUNT_W-1:0] alarm_count;
    } t_out_beat;

    typedef struct packed {
        logic advance;  // take the neighbor's record, ring moves one place
        logic store;    // overwrite own time with the event time
    } t_cell_ctl;

endpackage

@@ sv/fpbd_cell.sv @@
// One cell of the record-time chain: a 48-bit record time and an occupied flag.
// Depends on fpbd_pkg.
module fpbd_cell
    import fpbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [TIME_W-1:0] i_prev_time,
    input  logic              i_prev_valid,
    input  logic [TIME_W-1:0] i_now,
    output logic [TIME_W-1:0] o_time,
    output logic              o_valid
);

    logic [TIME_W-1:0] r_time;
    logic              r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_valid <= 1'b0;
        end else if (i_ctl.advance) begin
            r_time  <= i_prev_time;
            r_valid <= i_prev_valid;
        end else if (i_ctl.store) begin
            r_time  <= i_now;
        end
    end

    assign o_time  = r_time;
    assign o_valid = r_valid;

endmodule

@@ sv/full_poll_burst_detector.sv @@
// Full-poll burst detector. An accepted event beat's result is registered and shows in the
// cycle after. Throughput: one event per cycle; the head cell time, the mask and the counter
// are read and rewritten in the same cycle. The input stalls only while a result is held by
// an output stall. Reset (synchronous, active low) clears the cells, the mask and the
// alarm counter and restores the register defaults at once; there is no clearing pass.
module full_poll_burst_detector
    import fpbd_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration, thresholds held in milliseconds.
    logic                   r_enable;
    logic [CONTIG_MS_W-1:0] r_contig_ms;
    logic [WINDOW_MS_W-1:0] r_window_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_contig_ms <= CONTIG_MS_RST;
            r_window_ms <= WINDOW_MS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_CONTIG: r_contig_ms <= CONTIG_MS_W'(i_cfg_data[CONTIG_W-1:0])
                                         * CONTIG_MS_W'(MS_PER_SEC);
                CFG_WINDOW: r_window_ms <= WINDOW_MS_W'(i_cfg_data[WINDOW_W-1:0])
                                         * WINDOW_MS_W'(MS_PER_SEC);
                default: ;
            endcase
        end
    end

    logic              r_out_valid;
    t_out_beat         r_out;
    logic [MASK_W-1:0] r_mask;
    logic [COUNT_W-1:0] r_total;

    logic              w_in_acc;
    logic              w_event;
    logic [TIME_W-1:0] w_time [RING_DEPTH];
    logic              w_valid [RING_DEPTH];
    logic [TIME_W-1:0] w_gap;
    logic [TIME_W-1:0] w_span;
    logic [MASK_W-1:0] w_mask;
    logic              w_complete;
    logic              w_alarm;
    logic [COUNT_W-1:0] n_total;
    t_cell_ctl         w_ctl_head;
    t_cell_ctl         w_ctl_body;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_event    = w_in_acc && r_enable;

    // Cell 0 holds the record being filled; the last cell holds the oldest record
    // once the ring is full.
    assign w_gap      = i_in_data.now_ms - w_time[0];
    assign w_span     = i_in_data.now_ms - w_time[RING_DEPTH-1];
    assign w_mask     = ((w_gap >= TIME_W'(r_contig_ms)) ? '0 : r_mask)
                        | i_in_data.request_mask;
    assign w_complete = w_event && (w_mask == ALL_REQUESTS);
    assign w_alarm    = w_complete && w_valid[RING_DEPTH-1]
                        && (w_span < TIME_W'(r_window_ms));
    assign n_total    = (w_alarm && (r_total != COUNT_MAX)) ? r_total + 1'b1 : r_total;

    assign w_ctl_head = '{advance: w_complete, store: w_event};
    assign w_ctl_body = '{advance: w_complete, store: 1'b0};

    genvar g;
    generate
        for (g = 0; g < RING_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                // A completed record starts a fresh one with time zero.
                fpbd_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl_head),
                    .i_prev_time  ('0),
                    .i_prev_valid (1'b1),
                    .i_now        (i_in_data.now_ms),
                    .o_time       (w_time[g]),
                    .o_valid      (w_valid[g])
                );
            end else if (g == 1) begin : g_second
                // The completed record moves here carrying the event time.
                fpbd_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl_body),
                    .i_prev_time  (i_in_data.now_ms),
                    .i_prev_valid (1'b1),
                    .i_now        (i_in_data.now_ms),
                    .o_time       (w_time[g]),
                    .o_valid      (w_valid[g])
                );
            end else begin : g_body
                fpbd_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (w_ctl_body),
                    .i_prev_time  (w_time[g-1]),
                    .i_prev_valid (w_valid[g-1]),
                    .i_now        (i_in_data.now_ms),
                    .o_time       (w_time[g]),
                    .o_valid      (w_valid[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_total <= '0;
        end else if (w_event) begin
            r_mask  <= w_complete ? '0 : w_mask;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out.complete    <= w_complete;
            r_out.alarm       <= w_alarm;
            r_out.alarm_count <= n_total;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_alarm_needs_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.alarm |-> o_out_data.complete)
        else $error("alarm reported without a complete poll");

    a_total_steps_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_total == $past(r_total)) || (r_total == $past(r_total) + 1'b1))
        else $error("alarm counter jumped");

    a_ring_fills_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[RING_DEPTH-1] |-> w_valid[1])
        else $error("ring occupancy out of order");

    a_no_alarm_when_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !r_enable |=> !o_out_data.complete && !o_out_data.alarm)
        else $error("event processed while disabled");
`endif

endmodule
